// ===== sv/slpg_pkg.sv =====
// Package for the status LED pattern generator: mode codes, divisor constants,
// the breathing wave table and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package slpg_pkg;

  localparam int unsigned SINE_TABLE_DEPTH = 256;
  localparam int unsigned WAVE_IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned WAVE_W = 16;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_RECORDING = 3'd1,
    MODE_UNPAIRED  = 3'd2,
    MODE_SYNCING   = 3'd3,
    MODE_ERROR     = 3'd4
  } mode_t;

  localparam logic [2:0] MODE_LAST = 3'd4;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_SET   = 2'd1;
  localparam logic [1:0] FUNC_FLASH = 2'd2;

  // divide by constant: quotient estimate = (num * RCP) >> RCP_SHIFT, low by at most one
  localparam int unsigned PERIOD_W = 12;
  localparam int unsigned RCP_SHIFT = 39;
  localparam int unsigned RCP_W = 33;
  localparam int unsigned QUOT_W = 26;
  localparam logic [63:0] RCP_ONE = 64'd1 << RCP_SHIFT;

  localparam logic [PERIOD_W-1:0] PERIOD_UNPAIRED  = 12'd2200;
  localparam logic [PERIOD_W-1:0] PERIOD_SYNCING   = 12'd2600;
  localparam logic [PERIOD_W-1:0] PERIOD_ERR_RING  = 12'd140;
  localparam logic [PERIOD_W-1:0] PERIOD_UNP_LED   = 12'd700;
  localparam logic [PERIOD_W-1:0] PERIOD_SYNC_LED  = 12'd180;
  localparam logic [PERIOD_W-1:0] PERIOD_ERR_LED   = 12'd120;

  localparam logic [RCP_W-1:0] RCP_UNPAIRED = 33'(RCP_ONE / 64'd2200);
  localparam logic [RCP_W-1:0] RCP_SYNCING  = 33'(RCP_ONE / 64'd2600);
  localparam logic [RCP_W-1:0] RCP_ERR_RING = 33'(RCP_ONE / 64'd140);
  localparam logic [RCP_W-1:0] RCP_UNP_LED  = 33'(RCP_ONE / 64'd700);
  localparam logic [RCP_W-1:0] RCP_SYNC_LED = 33'(RCP_ONE / 64'd180);
  localparam logic [RCP_W-1:0] RCP_ERR_LED  = 33'(RCP_ONE / 64'd120);

  localparam logic [6:0] AMBER_SPAN = 7'd74;
  localparam logic [7:0] AMBER_BASE = 8'd18;
  localparam logic [6:0] SYNC_SPAN  = 7'd50;
  localparam logic [7:0] SYNC_BASE  = 8'd6;

  localparam logic [7:0] REC_RED    = 8'd255;
  localparam logic [7:0] REC_GREEN  = 8'd116;
  localparam logic [7:0] REC_BLUE   = 8'd44;
  localparam logic [7:0] AMBER_BLUE = 8'd2;
  localparam logic [7:0] ERR_RED    = 8'd180;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef logic [WAVE_W-1:0] wave_rom_t [SINE_TABLE_DEPTH];

  function automatic logic [63:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x = (r * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    sum = x;
    term = ((x * x2) >> 30) / 64'd6;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - term;
    return sum;
  endfunction

  function automatic logic [WAVE_W-1:0] wave_entry(input logic [63:0] k);
    logic [63:0] a;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] v;
    a = (k % SINE_TABLE_DEPTH) * 64'd4;
    q = a / SINE_TABLE_DEPTH;
    r = a % SINE_TABLE_DEPTH;
    if (q[0]) begin
      r = 64'(SINE_TABLE_DEPTH) - r;
    end
    s = quarter_sine(r);
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    if (q >= 64'd2) begin
      v = ONE_Q30 - s;
    end else begin
      v = ONE_Q30 + s;
    end
    v = (v + 64'd16384) >> 15;
    if (v > 64'd65535) begin
      v = 64'd65535;
    end
    return v[WAVE_W-1:0];
  endfunction

  function automatic wave_rom_t build_wave_rom();
    wave_rom_t rom;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      rom[k] = wave_entry(64'(k));
    end
    return rom;
  endfunction

  localparam wave_rom_t WAVE_ROM = build_wave_rom();

  typedef struct packed {
    logic accept;
    logic mul;
    logic qp;
    logic rem;
    logic reload;
    logic rom;
    logic scale;
    logic emit;
  } slpg_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_tick;
    logic breathe;
    logic out_free;
  } slpg_sts_t;

endpackage

`default_nettype wire

// ===== sv/slpg_ctrl.sv =====
// Sequencer for the status LED pattern generator: steps the datapath through
// accept, divide-by-constant passes, wave lookup, scaling and result load.
// Depends on slpg_pkg.
`default_nettype none

module slpg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire slpg_pkg::slpg_sts_t sts,
  output slpg_pkg::slpg_cmd_t    cmd,
  output logic                   in_stall
);
  import slpg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_QP,
    S_REM,
    S_RELOAD,
    S_ROM,
    S_SCALE,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   pass_r;
  logic   pass_nxt;

  always_comb begin
    state_nxt = state_r;
    pass_nxt = pass_r;
    case (state_r)
      S_IDLE: begin
        if (sts.in_valid && sts.in_tick) begin
          state_nxt = S_MUL;
          pass_nxt = 1'b0;
        end
      end
      S_MUL: state_nxt = S_QP;
      S_QP: state_nxt = S_REM;
      S_REM: begin
        if (sts.breathe && !pass_r) begin
          state_nxt = S_RELOAD;
          pass_nxt = 1'b1;
        end else if (sts.breathe) begin
          state_nxt = S_ROM;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_RELOAD: state_nxt = S_MUL;
      S_ROM: state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_RESULT;
      S_RESULT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
          pass_nxt = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r <= pass_nxt;
    end
  end

  always_comb begin
    cmd.accept = (state_r == S_IDLE) && sts.in_valid;
    cmd.mul = (state_r == S_MUL);
    cmd.qp = (state_r == S_QP);
    cmd.rem = (state_r == S_REM);
    cmd.reload = (state_r == S_RELOAD);
    cmd.rom = (state_r == S_ROM);
    cmd.scale = (state_r == S_SCALE);
    cmd.emit = (state_r == S_RESULT) && sts.out_free;
  end

  assign in_stall = (state_r != S_IDLE);

  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && sts.in_valid && sts.in_tick) |=> state_r == S_MUL)
    else $error("tick beat did not start a division pass");

  a_pass_breathe: assert property (@(posedge clk) disable iff (!rst_n)
    pass_r |-> sts.breathe)
    else $error("second division pass outside a breathing pattern");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && !sts.out_free) |=> state_r == S_RESULT)
    else $error("result dropped while output register full");

endmodule

`default_nettype wire

// ===== sv/slpg_dp.sv =====
// Datapath of the status LED pattern generator: mode and deadline state,
// shared divide-by-constant unit, wave table, scaling and output register.
// Depends on slpg_pkg; driven by slpg_ctrl.
`default_nettype none

module slpg_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire slpg_pkg::slpg_cmd_t cmd,
  output slpg_pkg::slpg_sts_t      sts,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_func,
  input  wire logic [2:0]          in_mode_value,
  input  wire logic [31:0]         in_now_ms,
  input  wire logic                use_ring,
  input  wire logic [15:0]         error_hold_ms,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_red,
  output logic [7:0]               out_green,
  output logic [7:0]               out_blue,
  output logic                     out_led_on,
  output logic [2:0]               out_current_mode
);
  import slpg_pkg::*;

  mode_t                 mode_r;
  logic [31:0]           deadline_r;
  logic [31:0]           num_r;
  logic [QUOT_W-1:0]     quot_r;
  logic [31:0]           qp_r;
  logic [PERIOD_W-1:0]   rem_r;
  logic [WAVE_W-1:0]     wave_r;
  logic [7:0]            level_r;
  logic                  out_valid_r;
  logic [7:0]            red_r;
  logic [7:0]            green_r;
  logic [7:0]            blue_r;
  logic                  led_r;
  logic [2:0]            cur_mode_r;

  logic [PERIOD_W-1:0]   period;
  logic [RCP_W-1:0]      recip;
  logic [64:0]           mul_full;
  logic [37:0]           qp_full;
  logic [31:0]           diff;
  logic                  corr;
  logic [31:0]           diff_fix;
  logic [22:0]           scale_prod;
  logic [6:0]            span;
  logic [7:0]            base;
  logic [7:0]            red_nxt;
  logic [7:0]            green_nxt;
  logic [7:0]            blue_nxt;
  logic                  led_nxt;
  logic                  lit;
  logic                  out_free;

  function automatic logic [7:0] div5(input logic [9:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd205;
    return p[17:10];
  endfunction

  always_comb begin
    period = PERIOD_ERR_LED;
    recip = RCP_ERR_LED;
    if (use_ring) begin
      case (mode_r)
        MODE_UNPAIRED: begin
          period = PERIOD_UNPAIRED;
          recip = RCP_UNPAIRED;
        end
        MODE_SYNCING: begin
          period = PERIOD_SYNCING;
          recip = RCP_SYNCING;
        end
        default: begin
          period = PERIOD_ERR_RING;
          recip = RCP_ERR_RING;
        end
      endcase
    end else begin
      case (mode_r)
        MODE_UNPAIRED: begin
          period = PERIOD_UNP_LED;
          recip = RCP_UNP_LED;
        end
        MODE_SYNCING: begin
          period = PERIOD_SYNC_LED;
          recip = RCP_SYNC_LED;
        end
        default: begin
          period = PERIOD_ERR_LED;
          recip = RCP_ERR_LED;
        end
      endcase
    end
  end

  assign mul_full = 65'(num_r) * 65'(recip);
  assign qp_full = 38'(quot_r) * 38'(period);
  assign diff = num_r - qp_r;
  assign corr = (diff >= 32'(period));
  assign diff_fix = corr ? (diff - 32'(period)) : diff;

  assign span = (mode_r == MODE_SYNCING) ? SYNC_SPAN : AMBER_SPAN;
  assign base = (mode_r == MODE_SYNCING) ? SYNC_BASE : AMBER_BASE;
  assign scale_prod = 23'(wave_r) * 23'(span);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    red_nxt = 8'd0;
    green_nxt = 8'd0;
    blue_nxt = 8'd0;
    led_nxt = 1'b0;
    lit = !quot_r[0];
    if (use_ring) begin
      case (mode_r)
        MODE_RECORDING: begin
          red_nxt = REC_RED;
          green_nxt = REC_GREEN;
          blue_nxt = REC_BLUE;
        end
        MODE_UNPAIRED: begin
          red_nxt = level_r;
          green_nxt = {1'b0, level_r[7:1]};
          blue_nxt = AMBER_BLUE;
        end
        MODE_SYNCING: begin
          red_nxt = div5({1'b0, level_r, 1'b0});
          green_nxt = div5(10'(level_r) * 10'd3);
          blue_nxt = level_r;
        end
        MODE_ERROR: begin
          red_nxt = lit ? ERR_RED : 8'd0;
        end
        default: red_nxt = 8'd0;
      endcase
    end else begin
      case (mode_r)
        MODE_RECORDING: led_nxt = 1'b1;
        MODE_UNPAIRED, MODE_SYNCING, MODE_ERROR: led_nxt = lit;
        default: led_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      deadline_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        case (in_func)
          FUNC_SET: begin
            if (in_mode_value <= MODE_LAST) begin
              mode_r <= mode_t'(in_mode_value);
            end
          end
          FUNC_FLASH: begin
            deadline_r <= in_now_ms + 32'(error_hold_ms);
            mode_r <= MODE_ERROR;
          end
          FUNC_TICK: begin
            if (mode_r == MODE_ERROR && in_now_ms > deadline_r) begin
              mode_r <= MODE_IDLE;
            end
          end
          default: mode_r <= mode_r;
        endcase
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      num_r <= in_now_ms;
    end else if (cmd.reload) begin
      num_r <= 32'(rem_r) << WAVE_IDX_W;
    end
    if (cmd.mul) begin
      quot_r <= mul_full[RCP_SHIFT +: QUOT_W];
    end else if (cmd.rem) begin
      quot_r <= quot_r + QUOT_W'(corr);
    end
    if (cmd.qp) begin
      qp_r <= qp_full[31:0];
    end
    if (cmd.rem) begin
      rem_r <= diff_fix[PERIOD_W-1:0];
    end
    if (cmd.rom) begin
      wave_r <= WAVE_ROM[quot_r[WAVE_IDX_W-1:0]];
    end
    if (cmd.scale) begin
      level_r <= base + 8'(scale_prod[22:16]);
    end
    if (cmd.emit) begin
      red_r <= red_nxt;
      green_r <= green_nxt;
      blue_r <= blue_nxt;
      led_r <= led_nxt;
      cur_mode_r <= mode_r;
    end
  end

  always_comb begin
    sts.in_valid = in_valid;
    sts.in_tick = (in_func == FUNC_TICK);
    sts.breathe = use_ring && (mode_r == MODE_UNPAIRED || mode_r == MODE_SYNCING);
    sts.out_free = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_red = red_r;
  assign out_green = green_r;
  assign out_blue = blue_r;
  assign out_led_on = led_r;
  assign out_current_mode = cur_mode_r;

  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.rem) |-> (38'(quot_r) * 38'(period) + 38'(rem_r)) == 38'(num_r))
    else $error("divide-by-constant quotient and remainder disagree");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.rem) |-> rem_r < period)
    else $error("remainder not below the period after correction");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(use_ring && led_nxt))
    else $error("fallback LED driven in ring mode");

endmodule

`default_nettype wire

// ===== sv/status_led_pattern_generator.sv =====
// Top level of the status LED pattern generator: configuration registers and
// the sequencer/datapath pair. Depends on slpg_pkg, slpg_ctrl and slpg_dp.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    in_func, in_mode_value, in_now_ms
//   out_     output     out_valid / out_stall  out_red/green/blue, out_led_on,
//                                              out_current_mode
//   config   input      psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// A set-mode or flash-error beat is taken in the idle state and gives no result.
// A tick runs the shared divide-by-constant unit (multiply, quotient product and
// remainder steps) once for the period phase and, for a breathing pattern, once
// more for the wave table index, followed by lookup and scaling, then the result.
// Reset (rst_n low, synchronous) sets idle mode, deadline 0, use_ring 1, hold 1600.
// A full, stalled output register holds the finished result; the next beat
// is taken once it drains.
`default_nettype none

module status_led_pattern_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [2:0]  in_mode_value,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_led_on,
  output logic [2:0]       out_current_mode,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import slpg_pkg::*;

  localparam logic REG_USE_RING = 1'b0;
  localparam logic REG_HOLD = 1'b1;

  logic        use_ring_r;
  logic [15:0] hold_r;
  logic        cfg_wr;
  slpg_cmd_t   cmd;
  slpg_sts_t   sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_ring_r <= 1'b1;
      hold_r <= 16'd1600;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_USE_RING: use_ring_r <= pwdata[0];
        REG_HOLD: hold_r <= pwdata[15:0];
        default: use_ring_r <= use_ring_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_USE_RING: prdata = {31'd0, use_ring_r};
      REG_HOLD: prdata = {16'd0, hold_r};
      default: prdata = 32'd0;
    endcase
  end

  slpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  slpg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_valid         (in_valid),
    .in_func          (in_func),
    .in_mode_value    (in_mode_value),
    .in_now_ms        (in_now_ms),
    .use_ring         (use_ring_r),
    .error_hold_ms    (hold_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_led_on       (out_led_on),
    .out_current_mode (out_current_mode)
  );

endmodule

`default_nettype wire
